// File: rtl/mrc_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and crc-16 step for the modbus rtu response checker
// no dependencies
package mrc_pkg;

    localparam int ByteW   = 8;
    localparam int PosW    = 9;
    localparam int StatusW = 3;
    localparam int LenW    = 9;
    localparam int CrcW    = 16;
    localparam int CfgIdxW = 1;

    localparam logic [CrcW-1:0]  CrcInit      = 16'hFFFF;
    localparam logic [CrcW-1:0]  CrcPoly      = 16'hA001;
    localparam logic [ByteW-1:0] MaxDataCount = 8'd252;

    localparam logic [CfgIdxW-1:0] RegDeviceId = 1'd0;
    localparam logic [CfgIdxW-1:0] RegFunction = 1'd1;

    localparam logic [ByteW-1:0] DeviceIdReset = 8'd1;
    localparam logic [ByteW-1:0] FunctionReset = 8'd3;

    localparam logic [StatusW-1:0] StatOk        = 3'd0;
    localparam logic [StatusW-1:0] StatBadDevice = 3'd1;
    localparam logic [StatusW-1:0] StatBadFunc   = 3'd2;
    localparam logic [StatusW-1:0] StatCrcErr    = 3'd3;
    localparam logic [StatusW-1:0] StatCountErr  = 3'd4;

    typedef struct packed {
        logic               emit;
        logic [StatusW-1:0] status;
        logic [LenW-1:0]    frame_length;
    } t_result;

    function automatic logic [CrcW-1:0] crc_step(input logic [CrcW-1:0] crc,
                                                input logic [ByteW-1:0] b);
        logic [CrcW-1:0] c;
        c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/mrc_core.sv
`timescale 1ns / 1ps
// frame state and per-byte verdict logic of the modbus rtu response checker
// depends on mrc_pkg
module mrc_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [mrc_pkg::ByteW-1:0] i_byte,
    input  logic                      i_start,
    input  logic [mrc_pkg::ByteW-1:0] i_device_id,
    input  logic [mrc_pkg::ByteW-1:0] i_function,
    output mrc_pkg::t_result          o_result
);
    import mrc_pkg::*;

    logic [PosW-1:0]  r_pos,   n_pos;
    logic [ByteW-1:0] r_count, n_count;
    logic [CrcW-1:0]  r_crc,   n_crc;
    logic             r_low,   n_low;
    logic             r_done,  n_done;

    logic [PosW-1:0]  e_pos;
    logic [ByteW-1:0] e_count;
    logic [CrcW-1:0]  e_crc;
    logic             e_low;
    logic             e_done;
    logic [PosW-1:0]  crc_at;
    t_result          res;

    always_comb begin
        e_pos   = i_start ? '0 : r_pos;
        e_count = i_start ? '0 : r_count;
        e_crc   = i_start ? CrcInit : r_crc;
        e_low   = i_start ? 1'b0 : r_low;
        e_done  = i_start ? 1'b0 : r_done;

        n_pos   = e_pos;
        n_count = e_count;
        n_crc   = e_crc;
        n_low   = e_low;
        n_done  = e_done;

        res.emit         = 1'b0;
        res.status       = StatOk;
        res.frame_length = '0;
        crc_at           = '0;

        if (!e_done) begin
            if (e_pos == PosW'(0) && i_byte != i_device_id) begin
                res.emit   = 1'b1;
                res.status = StatBadDevice;
            end else if (e_pos == PosW'(1) && i_byte != i_function) begin
                res.emit   = 1'b1;
                res.status = StatBadFunc;
            end else if (e_pos == PosW'(2) && i_byte > MaxDataCount) begin
                n_count    = i_byte;
                res.emit   = 1'b1;
                res.status = StatCountErr;
            end else begin
                if (e_pos == PosW'(2)) begin
                    n_count = i_byte;
                end
                crc_at = PosW'(3) + {1'b0, n_count};
                if (e_pos < crc_at) begin
                    n_crc = crc_step(e_crc, i_byte);
                    n_pos = e_pos + PosW'(1);
                end else if (e_pos == crc_at) begin
                    n_low = (i_byte == e_crc[ByteW-1:0]);
                    n_pos = e_pos + PosW'(1);
                end else if (e_low && i_byte == e_crc[CrcW-1:ByteW]) begin
                    res.emit         = 1'b1;
                    res.status       = StatOk;
                    res.frame_length = crc_at + LenW'(2);
                end else begin
                    res.emit   = 1'b1;
                    res.status = StatCrcErr;
                end
            end
            if (res.emit) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_crc   <= CrcInit;
            r_low   <= 1'b0;
            r_done  <= 1'b1;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_count <= n_count;
            r_crc   <= n_crc;
            r_low   <= n_low;
            r_done  <= n_done;
        end
    end

    assign o_result = res;

endmodule

// File: rtl/modbus_rtu_response_checker_top.sv
`timescale 1ns / 1ps
// datapath: a byte is registered, judged by the core when it can advance, and its
// result registered; a held result register stalls the judging of the next byte
// throughput: one byte per cycle unless stalled by i_out_ready, with a combinational crc step
// reset: synchronous active low, clears handshakes and frame state, loads
// register defaults device id 1 and function 3; depends on mrc_pkg, mrc_core
module modbus_rtu_response_checker_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [mrc_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [mrc_pkg::ByteW-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mrc_pkg::ByteW-1:0]     i_rx_byte,
    input  logic                          i_frame_start,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mrc_pkg::StatusW-1:0]   o_status,
    output logic [mrc_pkg::LenW-1:0]      o_frame_length
);
    import mrc_pkg::*;

    logic [ByteW-1:0]   r_device_id;
    logic [ByteW-1:0]   r_function;
    logic               r_in_valid;
    logic [ByteW-1:0]   r_in_byte;
    logic               r_in_start;
    logic               r_out_valid;
    logic [StatusW-1:0] r_out_status;
    logic [LenW-1:0]    r_out_length;
    logic               advance;
    t_result            result;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= DeviceIdReset;
            r_function  <= FunctionReset;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                RegDeviceId: r_device_id <= i_cfg_wdata;
                RegFunction: r_function  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // request input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_rx_byte;
            r_in_start <= i_frame_start;
        end
    end

    mrc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_device_id (r_device_id),
        .i_function  (r_function),
        .o_result    (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && result.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.emit) begin
            r_out_status <= result.status;
            r_out_length <= result.frame_length;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_frame_length = r_out_length;

endmodule
